FILE: design/lz4d_pkg.sv
// ----------------------------------------------------------------------------
// lz4d_pkg
// Shared types and constants for the LZ4 block decoder.
// ----------------------------------------------------------------------------
package lz4d_pkg;

   localparam int HIST_AW = 16;

   typedef enum logic [2:0] {
      ST_DATA    = 3'd0,
      ST_ENDED   = 3'd1,
      ST_LIMIT   = 3'd2,
      ST_ZERO    = 3'd3,
      ST_BEYOND  = 3'd4
   } status_type;

endpackage

FILE: design/lz4d_history.sv
// ----------------------------------------------------------------------------
// lz4d_history
// 64 KiB history memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lz4d_history #(
   parameter int AW = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);
   logic [7:0] mem [0:(1<<AW)-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: design/lz4_block_tolerant_decoder.sv
// ----------------------------------------------------------------------------
// lz4_block_tolerant_decoder
// LZ4 block decoder: one compressed byte per item, packed output words.
// ----------------------------------------------------------------------------
// Sequence: a header or literal item goes IDLE, DECODE, POST, WAIT, back to IDLE;
// POST also sends a partial word out, and any wait on the output register holds it.
// A match item loops S_RD and S_WR once per copied byte (history read then write)
// and ends with a final check in S_RD before POST.
// One item at a time: a new byte is taken only back in S_IDLE.
// Reset: synchronous, active high; clears sequencer, counters, max_output=65536.
module lz4_block_tolerant_decoder #(
   parameter int BYTES_PER_RESULT = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // in_byte[7:0]
   input  logic         req_tlast,   // in_last
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // out_data[63:0], out_count[67:64], total_bytes[99:68]
   output logic [2:0]   rsp_tuser,   // out_status
   output logic         rsp_tlast,   // out_last
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);
   import lz4d_pkg::*;

   localparam int WB = (BYTES_PER_RESULT > 8) ? 8 : BYTES_PER_RESULT;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_RD, S_WR, S_FLUSH, S_STATUS, S_WAIT, S_POST
   } seq_type;

   typedef enum logic [2:0] {
      PH_TOKEN, PH_LITEXT, PH_LITERALS, PH_OFF_LO, PH_OFF_HI, PH_MEXT
   } phase_type;

   seq_type    seq_ff, seq_in;
   phase_type  phase_ff, phase_in;
   logic [31:0] max_ff, max_in, prod_ff, prod_in, lit_ff, lit_in;
   logic [15:0] off_ff, off_in;
   logic [3:0]  nib_ff, nib_in;
   logic        stop_ff, stop_in, last_ff, last_in, endm_ff, endm_in;
   logic [7:0]  byte_ff, byte_in;
   logic [8:0]  cnt_ff, cnt_in;   // bytes left to copy
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  fill_ff, fill_in;
   status_type  code_ff, code_in;
   logic        ov_ff, ov_in;
   logic [63:0] od_ff, od_in;
   logic [3:0]  oc_ff, oc_in;
   logic [2:0]  os_ff, os_in;
   logic [31:0] ot_ff, ot_in;
   logic        ol_ff, ol_in;

   logic        wr_en;
   logic [7:0]  wr_data, rd_data;
   logic [15:0] rd_addr;

   lz4d_history #(.AW(HIST_AW)) u_hist (
      .clock(clock), .wr_en(wr_en), .wr_addr(prod_ff[15:0]), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign rd_addr    = prod_ff[15:0] - off_ff;
   assign req_tready = (seq_ff == S_IDLE);
   assign csr_ready  = (seq_ff == S_IDLE) && !ov_ff;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {4'd0, ot_ff, oc_ff, od_ff};
   assign rsp_tuser  = os_ff;
   assign rsp_tlast  = ol_ff;

   always_comb begin
      logic [31:0] sum;
      logic        put;
      logic [7:0]  pb;
      sum = '0; put = 1'b0; pb = '0;
      seq_in = seq_ff; phase_in = phase_ff; max_in = max_ff;
      prod_in = prod_ff; lit_in = lit_ff; off_in = off_ff; nib_in = nib_ff;
      stop_in = stop_ff; last_in = last_ff; endm_in = endm_ff; byte_in = byte_ff;
      cnt_in = cnt_ff; acc_in = acc_ff; fill_in = fill_ff; code_in = code_ff;
      ov_in = ov_ff && !rsp_tready; od_in = od_ff; oc_in = oc_ff; os_in = os_ff;
      ot_in = ot_ff; ol_in = ol_ff;
      wr_en = 1'b0; wr_data = rd_data;
      if (csr_valid && csr_ready) max_in = csr_data;
      case (seq_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               byte_in = req_tdata; last_in = req_tlast; endm_in = 1'b0;
               seq_in = S_DECODE;
            end
         end
         S_DECODE: begin
            seq_in = S_POST;
            if (!stop_ff) begin
               case (phase_ff)
                  PH_LITEXT: begin
                     sum = lit_ff + {24'd0, byte_ff};
                     lit_in = (sum < lit_ff) ? 32'hFFFF_FFFF : sum;
                     if (byte_ff != 8'hFF) phase_in = PH_LITERALS;
                  end
                  PH_LITERALS: begin
                     put = 1'b1; pb = byte_ff;
                     lit_in = lit_ff - 32'd1;
                     if (lit_ff == 32'd1) begin
                        if (prod_ff + 32'd1 >= max_ff) begin
                           stop_in = 1'b1; code_in = ST_LIMIT; seq_in = S_FLUSH;
                        end else phase_in = PH_OFF_LO;
                     end
                  end
                  PH_OFF_LO: begin
                     off_in = {8'd0, byte_ff}; phase_in = PH_OFF_HI;
                  end
                  PH_OFF_HI: begin
                     off_in = {byte_ff, off_ff[7:0]};
                     if (off_in == 16'd0) begin
                        stop_in = 1'b1; code_in = ST_ZERO; seq_in = S_FLUSH;
                     end else if ({16'd0, off_in} > prod_ff) begin
                        stop_in = 1'b1; code_in = ST_BEYOND; seq_in = S_FLUSH;
                     end else begin
                        endm_in = (nib_ff != 4'hF);
                        phase_in = (nib_ff == 4'hF) ? PH_MEXT : PH_TOKEN;
                        cnt_in = (nib_ff == 4'hF) ? 9'd19 : {5'd0, nib_ff} + 9'd4;
                        seq_in = S_RD;
                     end
                  end
                  PH_MEXT: begin
                     endm_in = (byte_ff != 8'hFF);
                     cnt_in = {1'b0, byte_ff};
                     if (byte_ff != 8'hFF) phase_in = PH_TOKEN;
                     seq_in = S_RD;
                  end
                  default: begin
                     if (prod_ff >= max_ff) begin
                        stop_in = 1'b1; code_in = ST_LIMIT; seq_in = S_FLUSH;
                     end else begin
                        lit_in = {28'd0, byte_ff[7:4]};
                        nib_in = byte_ff[3:0];
                        if (byte_ff[7:4] == 4'hF) phase_in = PH_LITEXT;
                        else if (byte_ff[7:4] != 4'd0) phase_in = PH_LITERALS;
                        else phase_in = PH_OFF_LO;
                     end
                  end
               endcase
            end
         end
         S_RD: begin
            if (cnt_ff == 9'd0) begin
               seq_in = S_POST;
               if (endm_ff && prod_ff >= max_ff) begin
                  stop_in = 1'b1; code_in = ST_LIMIT; seq_in = S_FLUSH;
               end
            end else if (!ov_ff || fill_ff != 4'(WB - 1)) seq_in = S_WR;
         end
         S_WR: begin
            put = 1'b1; pb = rd_data; cnt_in = cnt_ff - 9'd1; seq_in = S_RD;
         end
         S_FLUSH: begin
            if (!ov_in) begin
               if (fill_ff != 4'd0) begin
                  ov_in = 1'b1; od_in = acc_ff; oc_in = fill_ff; os_in = ST_DATA;
                  ot_in = prod_ff; ol_in = 1'b0; acc_in = '0; fill_in = '0;
               end else seq_in = S_STATUS;
            end
         end
         S_STATUS: begin
            if (!ov_in) begin
               ov_in = 1'b1; od_in = '0; oc_in = '0; os_in = code_ff;
               ot_in = prod_ff; ol_in = 1'b1; seq_in = S_WAIT;
            end
         end
         S_WAIT: begin
            if (!ov_in) begin
               if (last_ff) begin
                  prod_in = '0; phase_in = PH_TOKEN; lit_in = '0; off_in = '0;
                  nib_in = '0; stop_in = 1'b0;
               end
               seq_in = S_IDLE;
            end
         end
         S_POST: begin
            if (!stop_ff && last_ff) begin
               stop_in = 1'b1; seq_in = S_FLUSH;
               code_in = (prod_ff >= max_ff) ? ST_LIMIT : ST_ENDED;
            end else if (fill_ff != 4'd0) begin
               if (!ov_in) begin
                  ov_in = 1'b1; od_in = acc_ff; oc_in = fill_ff; os_in = ST_DATA;
                  ot_in = prod_ff; ol_in = 1'b0; acc_in = '0; fill_in = '0;
               end
            end else seq_in = S_WAIT;
         end
         default: seq_in = S_IDLE;
      endcase
      if (put) begin
         wr_en = 1'b1; wr_data = pb; prod_in = prod_ff + 32'd1;
         acc_in = acc_ff | ({56'd0, pb} << {fill_ff[2:0], 3'b000});
         fill_in = fill_ff + 4'd1;
         if (fill_in == 4'(WB)) begin
            // word full: output register is free here by construction
            ov_in = 1'b1; od_in = acc_in; oc_in = fill_in; os_in = ST_DATA;
            ot_in = prod_in; ol_in = 1'b0; acc_in = '0; fill_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= S_IDLE; phase_ff <= PH_TOKEN;
         max_ff <= 32'd65536; prod_ff <= '0; lit_ff <= '0; off_ff <= '0;
         nib_ff <= '0; stop_ff <= 1'b0; last_ff <= 1'b0; endm_ff <= 1'b0;
         cnt_ff <= '0; acc_ff <= '0; fill_ff <= '0; code_ff <= ST_DATA;
         ov_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in; phase_ff <= phase_in;
         max_ff <= max_in; prod_ff <= prod_in; lit_ff <= lit_in; off_ff <= off_in;
         nib_ff <= nib_in; stop_ff <= stop_in; last_ff <= last_in;
         endm_ff <= endm_in; cnt_ff <= cnt_in; acc_ff <= acc_in;
         fill_ff <= fill_in; code_ff <= code_in; ov_ff <= ov_in;
      end
      byte_ff <= byte_in; od_ff <= od_in; oc_ff <= oc_in; os_ff <= os_in;
      ot_ff <= ot_in; ol_ff <= ol_in;
   end

`ifndef SYNTHESIS
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (oc_ff <= 4'(WB))) else $error("count too large");
   a_status_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (oc_ff == 4'd0)) else $error("status carries data");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("ready while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("output dropped");
`endif
endmodule

FILE: test/lz4_block_tolerant_decoder_checker.sv
// ----------------------------------------------------------------------------
// lz4_block_tolerant_decoder_checker
// Watches the request, response and csr channels of the LZ4 block decoder,
// decodes each accepted byte in its own model and compares every response
// item field by field against the oldest expected word or status.
// ----------------------------------------------------------------------------
module lz4_block_tolerant_decoder_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tlast,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [103:0] rsp_tdata,
   input  logic [2:0]   rsp_tuser,
   input  logic         rsp_tlast,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [31:0]  csr_data,
   output int           fail_count,
   output int           pending,
   output int           word_count,
   output int           status_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import lz4d_pkg::*;

   typedef enum logic [2:0] {
      P_TOKEN, P_LITEXT, P_LITERALS, P_OFF_LO, P_OFF_HI, P_MEXT
   } parse_type;

   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  count;
      status_type  status;
      logic [31:0] total;
      logic        last;
   } decoded_type;

   decoded_type expected_q[$];

   logic [7:0]  hist_mem [0:65535];
   logic [31:0] out_len;
   parse_type   parse;
   logic [31:0] lit_left;
   logic [15:0] m_off;
   logic [3:0]  m_nib;
   logic        halted;
   logic [31:0] out_limit;
   logic [63:0] acc;
   logic [3:0]  fill;

   function automatic void push_item(logic [63:0] d, logic [3:0] c, status_type s, logic l);
      decoded_type e;
      e.data = d; e.count = c; e.status = s; e.total = out_len; e.last = l;
      expected_q.push_back(e);
   endfunction

   function automatic void flush_word();
      if (fill > 0) begin
         push_item(acc, fill, ST_DATA, 1'b0);
         acc = '0;
         fill = 0;
      end
   endfunction

   function automatic void put_byte(logic [7:0] b);
      hist_mem[out_len[15:0]] = b;
      out_len++;
      acc |= 64'(b) << (8 * fill);
      fill++;
      if (fill == 8) flush_word();
   endfunction

   function automatic void finish_block(status_type s);
      flush_word();
      push_item('0, 4'd0, s, 1'b1);
      halted = 1'b1;
   endfunction

   function automatic void copy_run(int n);
      for (int k = 0; k < n; k++) put_byte(hist_mem[16'(out_len - 32'(m_off))]);
   endfunction

   function automatic void rearm();
      out_len = 0; parse = P_TOKEN; lit_left = 0; m_off = 0; m_nib = 0; halted = 0;
   endfunction

   function automatic void decode_byte(logic [7:0] b, logic l);
      acc = '0;
      fill = 0;
      if (halted) begin
         if (l) rearm();
         return;
      end
      case (parse)
         P_LITEXT: begin
            lit_left = (lit_left > 32'hFFFF_FFFF - b) ? 32'hFFFF_FFFF : lit_left + b;
            if (b != 8'hFF) parse = P_LITERALS;
         end
         P_LITERALS: begin
            put_byte(b);
            lit_left--;
            if (lit_left == 0) begin
               if (out_len >= out_limit) finish_block(ST_LIMIT);
               else parse = P_OFF_LO;
            end
         end
         P_OFF_LO: begin
            m_off[7:0] = b;
            parse = P_OFF_HI;
         end
         P_OFF_HI: begin
            m_off[15:8] = b;
            if (m_off == 0) finish_block(ST_ZERO);
            else if (32'(m_off) > out_len) finish_block(ST_BEYOND);
            else if (m_nib == 4'hF) begin
               copy_run(19);
               parse = P_MEXT;
            end else begin
               copy_run(m_nib + 4);
               if (out_len >= out_limit) finish_block(ST_LIMIT);
               else parse = P_TOKEN;
            end
         end
         P_MEXT: begin
            copy_run(b);
            if (b != 8'hFF) begin
               if (out_len >= out_limit) finish_block(ST_LIMIT);
               else parse = P_TOKEN;
            end
         end
         default: begin
            if (out_len >= out_limit) finish_block(ST_LIMIT);
            else begin
               lit_left = b[7:4];
               m_nib = b[3:0];
               if (lit_left == 15) parse = P_LITEXT;
               else if (lit_left > 0) parse = P_LITERALS;
               else parse = P_OFF_LO;
            end
         end
      endcase
      if (!halted && l) finish_block(out_len >= out_limit ? ST_LIMIT : ST_ENDED);
      else flush_word();
      if (l) rearm();
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t ERROR %s: got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      decoded_type e;
      if (reset) begin
         rearm();
         out_limit = 32'd65536;
         expected_q.delete();
         fail_count = 0;
         word_count = 0;
         status_count = 0;
      end else begin
         if (csr_valid && csr_ready) out_limit = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata[63:0], 0);
            end else begin
               e = expected_q.pop_front();
               if (rsp_tdata[63:0] !== e.data) report_mismatch("out_data", rsp_tdata[63:0], e.data);
               if (rsp_tdata[67:64] !== e.count)
                  report_mismatch("out_count", rsp_tdata[67:64], e.count);
               if (rsp_tdata[99:68] !== e.total)
                  report_mismatch("total_bytes", rsp_tdata[99:68], e.total);
               if (rsp_tuser !== e.status) report_mismatch("out_status", rsp_tuser, e.status);
               if (rsp_tlast !== e.last) report_mismatch("out_last", rsp_tlast, e.last);
               if (e.last) status_count++;
               else word_count++;
            end
         end
         if (req_tvalid && req_tready) decode_byte(req_tdata, req_tlast);
      end
      pending = expected_q.size();
   end

endmodule

FILE: test/tb_lz4_block_tolerant_decoder.sv
// ----------------------------------------------------------------------------
// tb_lz4_block_tolerant_decoder
// Drives LZ4 blocks (well-formed sequences, overlapping matches, bad offsets,
// truncation, limit stops, random noise) with request gaps, and response stalls
// in random phases, over several max_output settings; checker predicts, compares.
// ----------------------------------------------------------------------------
module tb_lz4_block_tolerant_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 5000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [103:0] rsp_tdata;
   logic [2:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_valid;
   logic         csr_ready;
   logic [31:0]  csr_data;
   int           fail_count;
   int           pending;
   int           word_count;
   int           status_count;
   int           idle_cycles;
   int           bytes_sent;
   logic         rsp_gaps;

   byte unsigned blk[$];
   int           blk_len;    // bytes of output the sequences added so far to the current block produce

   lz4_block_tolerant_decoder u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   lz4_block_tolerant_decoder_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending),
      .word_count(word_count), .status_count(status_count)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // watchdog: cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout, %0d items still expected", pending);
         $display("tb_lz4_block_tolerant_decoder NOT OK");
         $finish;
      end
   end

   // response side stalls
   initial begin
      int g;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         g = rsp_gaps ? gap_len() : 0;
         rsp_tready = 1'b0;
         repeat (g) @(negedge clock);
         rsp_tready = 1'b1;
         @(negedge clock);
      end
   end

   task automatic send_byte(byte unsigned b, logic l);
      repeat (gap_len()) @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = b;
      req_tlast = l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
      bytes_sent++;
   endtask

   task automatic send_block();
      byte unsigned b;
      while (blk.size() > 0) begin
         b = blk.pop_front();
         send_byte(b, blk.size() == 0);
      end
   endtask

   task automatic wait_drained();
      while (pending != 0) @(negedge clock);
      repeat (600) @(negedge clock);
   endtask

   task automatic write_limit(logic [31:0] v);
      csr_valid = 1'b1;
      csr_data = v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // one sequence: lit literals, then (if with_match) offset and match length
   task automatic add_seq(int lit, int mlen, bit with_match, int off);
      int ml;
      int x;
      ml = (mlen < 4) ? 0 : mlen - 4;
      blk.push_back(8'((lit >= 15 ? 15 : lit) << 4) | 8'(ml >= 15 ? 15 : ml));
      if (lit >= 15) begin
         x = lit - 15;
         while (x >= 255) begin blk.push_back(8'hFF); x -= 255; end
         blk.push_back(8'(x));
      end
      for (int k = 0; k < lit; k++) blk.push_back(8'($urandom));
      blk_len += lit;
      if (!with_match) return;
      blk.push_back(8'(off));
      blk.push_back(8'(off >> 8));
      if (ml >= 15) begin
         x = ml - 15;
         while (x >= 255) begin blk.push_back(8'hFF); x -= 255; end
         blk.push_back(8'(x));
      end
      blk_len += mlen;
   endtask

   task automatic random_block();
      int kind;
      int nseq;
      int lit;
      int mlen;
      blk_len = 0;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         // noise; history is only touched after at least one literal
         add_seq($urandom_range(1, 6), 4, 0, 0);
         repeat ($urandom_range(1, 10)) blk.push_back(8'($urandom));
      end else begin
         nseq = $urandom_range(1, 4);
         for (int s = 0; s < nseq; s++) begin
            lit = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 8);
            if (blk_len + lit == 0) lit = 1;
            mlen = ($urandom_range(0, 7) == 0) ? $urandom_range(19, 300) : $urandom_range(4, 18);
            add_seq(lit, mlen, 1, $urandom_range(1, blk_len + lit));
         end
         if (kind < 14) add_seq(1, 4, 1, 0);                  // zero offset
         else if (kind < 20) add_seq(1, 4, 1, blk_len + 2);   // offset past start
         else add_seq($urandom_range(0, 5), 4, 0, 0);         // final literal run
         if (kind >= 20 && kind < 28) begin
            // truncate
            void'(blk.pop_back());
            if (blk.size() > 2) void'(blk.pop_back());
         end
      end
      send_block();
   endtask

   initial begin
      bytes_sent = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      rsp_gaps = 1'b0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed: literals with all-ones/zeros, overlapping match, long match ext
      blk = '{8'h40, 8'hFF, 8'h00, 8'hAA, 8'h55, 8'h01, 8'h00,
              8'h0F, 8'h02, 8'h00, 8'hFF, 8'h03};
      send_block();
      blk = '{8'h10, 8'h7E, 8'h00, 8'h00, 8'h99};  // zero offset, then ignored byte
      send_block();
      blk = '{8'h10, 8'h7E, 8'h02, 8'h00};         // offset beyond output
      send_block();
      blk = '{8'hF0, 8'hFF, 8'h01};                // truncated after literal extension
      send_block();
      blk = '{8'h00};                               // lone token, input ended
      send_block();
      wait_drained();
      write_limit(32'd1);                           // stop after first run
      blk = '{8'h20, 8'h11, 8'h22, 8'h33, 8'h44};
      send_block();
      wait_drained();
      write_limit(32'hFFFF_FFFF);
      rsp_gaps = 1'b1;

      for (int phase_i = 0; phase_i < 4; phase_i++) begin
         repeat (2) random_block();
         wait_drained();   // sender holds off until all results are in
         case (phase_i)
            0: write_limit($urandom_range(1, 30));
            1: write_limit(32'd65536);
            2: write_limit($urandom_range(20, 200));
            default: write_limit(32'hFFFF_FFFF);
         endcase
      end
      rsp_gaps = 1'b0;
      repeat (2) random_block();

      wait_drained();
      $display("sent %0d request bytes; checked %0d data words and %0d status items",
               bytes_sent, word_count, status_count);
      if (fail_count == 0)
         $display("tb_lz4_block_tolerant_decoder OK");
      else
         $display("tb_lz4_block_tolerant_decoder NOT OK");
      $finish;
   end

endmodule
